// ----- rtl/mdsr_pkg.sv -----
// Shared types and constants for the motor duty smoothing ramp.
package mdsr_pkg;

  localparam int NumMotors = 4;
  localparam int FracBits  = 8;
  localparam int GainFrac  = 8;
  localparam int GainW     = 9;
  localparam int SpeedW    = 8;
  localparam int DutyW     = 10 + FracBits;
  localparam int ErrW      = DutyW + 1;
  localparam int ProdW     = ErrW + GainW + 1;
  localparam int StepW     = ProdW - GainFrac;
  localparam int SumW      = StepW + 1;
  localparam int MotorW    = (NumMotors > 1) ? $clog2(NumMotors) : 1;
  localparam int MagMax    = 255;

  localparam logic [GainW-1:0] GainReset = GainW'(77);

  localparam logic signed [DutyW-1:0] DutyMaxQ = {1'b0, {(DutyW-1){1'b1}}};
  localparam logic signed [DutyW-1:0] DutyMinQ = {1'b1, {(DutyW-1){1'b0}}};
  localparam logic signed [DutyW-1:0] LimQ     = DutyW'(MagMax * (2 ** FracBits));

  // Depth of the command queue and of the result queue.
  localparam int CmdDepth = 2;
  localparam int CmdPtrW  = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
  localparam int CmdCntW  = $clog2(CmdDepth + 1);
  localparam int ResDepth = 2;
  localparam int ResPtrW  = (ResDepth > 1) ? $clog2(ResDepth) : 1;
  localparam int ResCntW  = $clog2(ResDepth + 1);

  // Input command codes.
  localparam logic [2:0] CMD_FWD   = 3'd0;
  localparam logic [2:0] CMD_REV   = 3'd1;
  localparam logic [2:0] CMD_DECAY = 3'd2;
  localparam logic [2:0] CMD_CLEAR = 3'd3;
  localparam logic [2:0] CMD_APPLY = 3'd4;

  typedef enum logic [2:0] {
    OP_FWD,
    OP_REV,
    OP_DECAY,
    OP_CLEAR,
    OP_APPLY
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_WRITE,
    ST_APPLY
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [1:0]       motor;
    logic [SpeedW-1:0] speed;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

  typedef struct packed {
    logic [1:0] motor_index;
    logic       direction;
    logic [7:0] magnitude;
    logic       last;
  } res_t;

endpackage

// ----- rtl/mdsr_front.sv -----
// Front end: accepts items, classifies them and queues the ones that do work.
module mdsr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [2:0]        cmd_i,
  input  logic [1:0]        motor_i,
  input  logic [7:0]        speed_i,
  output mdsr_pkg::cmd_head_t head_o,
  input  logic              pop_i
);
  import mdsr_pkg::*;

  localparam logic [4:0] NumMotorsQ = 5'(NumMotors);

  cmd_t               mem_q [CmdDepth];
  logic [CmdPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CmdPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CmdCntW-1:0] cnt_q, cnt_d;
  op_e                op;
  logic               known;
  logic               keep;
  logic               enq;
  logic               deq;

  always_comb begin
    known = 1'b1;
    unique case (cmd_i)
      CMD_FWD:   op = OP_FWD;
      CMD_REV:   op = OP_REV;
      CMD_DECAY: op = OP_DECAY;
      CMD_CLEAR: op = OP_CLEAR;
      CMD_APPLY: op = OP_APPLY;
      default: begin
        op    = OP_APPLY;
        known = 1'b0;
      end
    endcase
  end

  // Unknown commands and updates of a missing motor are taken and dropped.
  assign keep = known && ((op == OP_APPLY) || ({3'b000, motor_i} < NumMotorsQ));

  assign full_o = (cnt_q == CmdCntW'(CmdDepth));
  assign enq    = push_i && !full_o && keep;
  assign deq    = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (enq) begin
      wr_ptr_d = (wr_ptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (deq) begin
      rd_ptr_d = (rd_ptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CmdCntW'(enq) - CmdCntW'(deq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      mem_q[wr_ptr_q] <= '{op: op, motor: motor_i, speed: speed_i};
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CmdCntW'(CmdDepth))
    else $error("command queue count above depth");

  a_drop_no_enq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full_o && !keep && !deq) |=> (cnt_q == $past(cnt_q)))
    else $error("dropped item changed the command queue");
`endif

endmodule

// ----- rtl/mdsr_back.sv -----
// Back end: executes queued commands on the duty registers and queues drive results.
module mdsr_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mdsr_pkg::GainW-1:0] cfg_gain_i,
  input  mdsr_pkg::cmd_head_t       head_i,
  output logic                      pop_o,
  input  logic                      res_pop_i,
  output logic                      res_empty_o,
  output mdsr_pkg::res_t            res_o
);
  import mdsr_pkg::*;

  state_e                    state_q, state_d;
  cmd_t                      cur_q;
  logic [MotorW-1:0]         cnt_q;
  logic [GainW-1:0]          gain_q;
  logic signed [ProdW-1:0]   prod_q;
  logic signed [DutyW-1:0]   duty_q [NumMotors];

  logic [MotorW-1:0]         rd_idx;
  logic signed [DutyW-1:0]   d_rd;
  logic signed [ErrW-1:0]    d_ext;
  logic signed [ErrW-1:0]    target;
  logic signed [ErrW-1:0]    err;
  logic signed [GainW:0]     gain_s;
  logic signed [ProdW-1:0]   prod;
  logic signed [StepW-1:0]   step;
  logic signed [SumW-1:0]    sum;
  logic signed [DutyW-1:0]   sat;
  logic signed [DutyW-1:0]   neg;

  logic                      duty_we;
  logic [MotorW-1:0]         duty_widx;
  logic signed [DutyW-1:0]   duty_wdata;
  logic                      cnt_last;
  logic                      res_push;
  res_t                      res_d;

  res_t                      res_mem_q [ResDepth];
  logic [ResPtrW-1:0]        res_wr_q, res_rd_q;
  logic [ResCntW-1:0]        res_cnt_q;
  logic                      res_full;
  logic                      res_deq;

  // Single read port on the duty registers.
  assign rd_idx = (state_q == ST_APPLY) ? cnt_q : MotorW'(cur_q.motor);
  assign d_rd   = duty_q[rd_idx];

  // Error and product for an update.
  assign d_ext  = ErrW'(d_rd);
  assign target = signed'({{(ErrW - SpeedW - FracBits){1'b0}}, cur_q.speed,
                           {FracBits{1'b0}}});
  always_comb begin
    unique case (cur_q.op)
      OP_FWD:  err = target - d_ext;
      OP_REV:  err = target + d_ext;
      default: err = d_ext;
    endcase
  end
  assign gain_s = signed'({1'b0, gain_q});
  assign prod   = err * gain_s;

  // The dropped low bits make this an arithmetic shift that rounds down.
  assign step = signed'(prod_q[ProdW-1:GainFrac]);
  assign sum  = (cur_q.op == OP_FWD) ? (SumW'(d_rd) + SumW'(step))
                                     : (SumW'(d_rd) - SumW'(step));
  always_comb begin
    priority if (sum > SumW'(DutyMaxQ)) begin
      sat = DutyMaxQ;
    end else if (sum < SumW'(DutyMinQ)) begin
      sat = DutyMinQ;
    end else begin
      sat = DutyW'(sum);
    end
  end

  // Drive readout of one motor.
  assign neg      = -d_rd;
  assign cnt_last = (cnt_q == MotorW'(NumMotors - 1));
  always_comb begin
    res_d.motor_index = 2'(cnt_q);
    res_d.last        = cnt_last;
    priority if (d_rd > LimQ) begin
      res_d.direction = 1'b0;
      res_d.magnitude = 8'(MagMax);
    end else if (d_rd > DutyW'(0)) begin
      res_d.direction = 1'b0;
      res_d.magnitude = d_rd[FracBits +: 8];
    end else if (d_rd > -LimQ) begin
      res_d.direction = 1'b1;
      res_d.magnitude = neg[FracBits +: 8];
    end else begin
      res_d.direction = 1'b1;
      res_d.magnitude = 8'(MagMax);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          unique case (head_i.cmd.op)
            OP_APPLY: state_d = ST_APPLY;
            OP_CLEAR: state_d = ST_IDLE;
            default:  state_d = ST_MUL;
          endcase
        end
      end
      ST_MUL:   state_d = ST_WRITE;
      ST_WRITE: state_d = ST_IDLE;
      ST_APPLY: begin
        if (!res_full && cnt_last) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    pop_o      = 1'b0;
    duty_we    = 1'b0;
    duty_widx  = MotorW'(cur_q.motor);
    duty_wdata = sat;
    res_push   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        pop_o = head_i.valid;
        if (head_i.valid && (head_i.cmd.op == OP_CLEAR)) begin
          duty_we    = 1'b1;
          duty_widx  = MotorW'(head_i.cmd.motor);
          duty_wdata = '0;
        end
      end
      ST_MUL:   ;
      ST_WRITE: duty_we = 1'b1;
      ST_APPLY: res_push = !res_full;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      gain_q  <= GainReset;
      for (int i = 0; i < NumMotors; i++) begin
        duty_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        gain_q <= cfg_gain_i;
      end
      if (pop_o) begin
        cnt_q <= '0;
      end else if (res_push) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (duty_we) begin
        duty_q[duty_widx] <= duty_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i.cmd;
    end
    if (state_q == ST_MUL) begin
      prod_q <= prod;
    end
  end

  // Result queue.
  assign res_full    = (res_cnt_q == ResCntW'(ResDepth));
  assign res_empty_o = (res_cnt_q == '0);
  assign res_deq     = res_pop_i && !res_empty_o;
  assign res_o       = res_mem_q[res_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q  <= '0;
      res_rd_q  <= '0;
      res_cnt_q <= '0;
    end else begin
      if (res_push) begin
        res_wr_q <= (res_wr_q == ResPtrW'(ResDepth - 1)) ? '0 : res_wr_q + 1'b1;
      end
      if (res_deq) begin
        res_rd_q <= (res_rd_q == ResPtrW'(ResDepth - 1)) ? '0 : res_rd_q + 1'b1;
      end
      res_cnt_q <= res_cnt_q + ResCntW'(res_push) - ResCntW'(res_deq);
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_mem_q[res_wr_q] <= res_d;
    end
  end

`ifndef SYNTHESIS
  a_mul_then_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |=> (state_q == ST_WRITE))
    else $error("multiply not followed by duty write");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && res_d.last) |-> (res_d.motor_index == 2'(NumMotors - 1)))
    else $error("last flag on a result that is not the final motor");

  a_res_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_q <= ResCntW'(ResDepth))
    else $error("result queue count above depth");
`endif

endmodule

// ----- rtl/motor_duty_smoothing_ramp.sv -----
// Top level of the per-motor duty smoothing ramp with drive readout.
// Four signed Q9.8 duties move toward a target by gain times the error on each
// update item; an apply item queues one drive result per motor in motor order.
// The front takes one item per cycle while not full into a two-entry command
// queue. The back runs a forward, reverse or decay update as dequeue, one
// error-times-gain multiply, then shift, add, saturate and write; it runs a
// clear in its dequeue step, and an apply as a dequeue and then one result
// per cycle while the result queue is not full into a two-entry result queue.
// Gain writes are taken at any edge with the write enable high.
module motor_duty_smoothing_ramp (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [2:0] cmd_i,
  input  logic [1:0] motor_i,
  input  logic [7:0] speed_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] motor_index_o,
  output logic       direction_o,
  output logic [7:0] magnitude_o,
  output logic       last_o,
  input  logic       cfg_we_i,
  input  logic [mdsr_pkg::GainW-1:0] cfg_gain_i
);
  import mdsr_pkg::*;

  cmd_head_t head;
  logic      head_pop;
  res_t      res;

  mdsr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .cmd_i   (cmd_i),
    .motor_i (motor_i),
    .speed_i (speed_i),
    .head_o  (head),
    .pop_i   (head_pop)
  );

  mdsr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_gain_i  (cfg_gain_i),
    .head_i      (head),
    .pop_o       (head_pop),
    .res_pop_i   (pop),
    .res_empty_o (empty),
    .res_o       (res)
  );

  assign motor_index_o = res.motor_index;
  assign direction_o   = res.direction;
  assign magnitude_o   = res.magnitude;
  assign last_o        = res.last;

endmodule
